// ----- design/i2c_eeprom_slave_defines.svh -----
// Assertion macros shared by the I2C EEPROM slave RTL.
`ifndef I2C_EEPROM_SLAVE_DEFINES_SVH
`define I2C_EEPROM_SLAVE_DEFINES_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define I2CE_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked on every rising clock edge outside reset.
`define I2CE_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- design/i2ce_pkg.sv -----
// Types and constants of the I2C EEPROM slave.
package i2ce_pkg;

   localparam int FUNC_W    = 2;
   localparam int BYTE_W    = 8;
   localparam int PTR_W     = 16;
   localparam int SIZE_W    = 17;
   localparam int CNT_W     = 5;
   localparam int CSR_IDX_W = 1;
   localparam int REQ_W     = 16;
   localparam int RSP_W     = 32;

   localparam logic [1:0]        ADDR_BYTES    = 2'd2;
   localparam logic [SIZE_W-1:0] ROM_SIZE_RST  = 17'd128;
   localparam logic [CNT_W-1:0]  MOD_STEPS_TOP = 5'(SIZE_W - 1);

   typedef enum logic [FUNC_W-1:0] {
      FUNC_EVENT = 2'd0,
      FUNC_WRITE = 2'd1,
      FUNC_READ  = 2'd2,
      FUNC_NACK  = 2'd3
   } func_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ROM_SIZE     = 1'b0,
      CSR_WRITE_ENABLE = 1'b1
   } csr_idx_type;

endpackage

// ----- design/i2c_eeprom_slave.sv -----
// I2C EEPROM slave: byte-level command handling, cell store and bit-serial pointer modulo.
// Start/stop, NACK and the first address byte go straight to the response; the second address byte
// reduces the pointer modulo the ROM size; a data byte accesses the cell, then advances the pointer
// modulo the ROM size; if the pointer is beyond the store, the 17-step remainder runs twice. One item in
// work at a time; req_tready rises in the cycle after the previous result is loaded into the output register.
// Reset clears control state, then a clearing pass zeroes every cell of the store (req_tready low).
`include "i2c_eeprom_slave_defines.svh"

module i2c_eeprom_slave #(
   parameter int MEM_DEPTH = 65536
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_we,
   input  logic [i2ce_pkg::CSR_IDX_W-1:0]  csr_addr,
   input  logic [i2ce_pkg::SIZE_W-1:0]     csr_wdata,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // func [1:0], write_data [9:2], zero [15:10]
   input  logic [i2ce_pkg::REQ_W-1:0]      req_tdata,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // read_data [7:0], flush_request [8], pointer_now [24:9], zero [31:25]
   output logic [i2ce_pkg::RSP_W-1:0]      rsp_tdata
);
   import i2ce_pkg::*;

   localparam int AW = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
   localparam logic [SIZE_W-1:0] DEPTH_C    = SIZE_W'(MEM_DEPTH);
   localparam logic [AW-1:0]     CLEAR_LAST = AW'(MEM_DEPTH - 1);

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_DIV,
      S_ACCESS,
      S_DONE
   } state_type;

   state_type            state_ff;
   func_type             func_ff;
   logic [BYTE_W-1:0]    data_ff;
   logic [PTR_W-1:0]     ptr_ff;
   logic [1:0]           seen_ff;
   logic                 changed_ff;
   logic                 flush_ff;
   logic [AW-1:0]        idx_ff;
   logic [AW-1:0]        clr_ff;
   logic [SIZE_W-1:0]    rem_ff;
   logic [SIZE_W-1:0]    dvd_ff;
   logic [SIZE_W-1:0]    dvs_ff;
   logic [CNT_W-1:0]     cnt_ff;
   logic                 mod_ptr_ff;
   logic [SIZE_W-1:0]    rom_size_ff;
   logic                 wen_ff;
   logic                 rsp_tvalid_ff;
   logic [RSP_W-1:0]     rsp_tdata_ff;
   logic [BYTE_W-1:0]    mem_q_ff;

   logic [BYTE_W-1:0]    mem_ff [MEM_DEPTH];

   func_type             func_in;
   logic [BYTE_W-1:0]    wdata_in;
   logic [SIZE_W-1:0]    eff_size_in;
   logic [SIZE_W:0]      trial_in;
   logic [SIZE_W-1:0]    rem_in;
   logic                 req_take;
   logic                 mem_we;
   logic [AW-1:0]        mem_wa;
   logic [BYTE_W-1:0]    mem_wd;

   assign func_in  = func_type'(req_tdata[FUNC_W-1:0]);
   assign wdata_in = req_tdata[FUNC_W+BYTE_W-1:FUNC_W];

   always_comb begin
      if (rom_size_ff == '0) begin
         eff_size_in = SIZE_W'(1);
      end else if (rom_size_ff > DEPTH_C) begin
         eff_size_in = DEPTH_C;
      end else begin
         eff_size_in = rom_size_ff;
      end
   end

   // restoring remainder, one dividend bit per cycle
   assign trial_in = {rem_ff, dvd_ff[SIZE_W-1]};
   assign rem_in   = (trial_in >= {1'b0, dvs_ff}) ? SIZE_W'(trial_in - {1'b0, dvs_ff})
                                                 : trial_in[SIZE_W-1:0];

   assign req_tready = (state_ff == S_IDLE);
   assign req_take   = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

   assign mem_we = (state_ff == S_CLEAR)
                || ((state_ff == S_ACCESS) && (func_ff == FUNC_WRITE) && wen_ff);
   assign mem_wa = (state_ff == S_CLEAR) ? clr_ff : idx_ff;
   assign mem_wd = (state_ff == S_CLEAR) ? '0 : data_ff;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem_ff[mem_wa] <= mem_wd;
      end
      mem_q_ff <= mem_ff[idx_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_CLEAR;
         clr_ff        <= '0;
         ptr_ff        <= '0;
         seen_ff       <= '0;
         changed_ff    <= 1'b0;
         rom_size_ff   <= ROM_SIZE_RST;
         wen_ff        <= 1'b1;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            unique case (csr_idx_type'(csr_addr))
               CSR_ROM_SIZE:     rom_size_ff <= csr_wdata;
               CSR_WRITE_ENABLE: wen_ff      <= csr_wdata[0];
               default:          ;
            endcase
         end

         if (rsp_tvalid_ff && rsp_tready && (state_ff != S_DONE)) begin
            rsp_tvalid_ff <= 1'b0;
         end

         unique case (state_ff)
            S_CLEAR: begin
               clr_ff <= clr_ff + AW'(1);
               if (clr_ff == CLEAR_LAST) begin
                  state_ff <= S_IDLE;
               end
            end
            S_IDLE: begin
               if (req_take) begin
                  func_ff  <= func_in;
                  data_ff  <= wdata_in;
                  flush_ff <= (func_in == FUNC_EVENT) ? changed_ff : 1'b0;
                  unique case (func_in)
                     FUNC_EVENT: begin
                        seen_ff    <= '0;
                        changed_ff <= 1'b0;
                        state_ff   <= S_DONE;
                     end
                     FUNC_WRITE, FUNC_READ: begin
                        if ((func_in == FUNC_WRITE) && (seen_ff < ADDR_BYTES)) begin
                           ptr_ff  <= {ptr_ff[BYTE_W-1:0], wdata_in};
                           seen_ff <= seen_ff + 2'd1;
                           if (seen_ff == ADDR_BYTES - 2'd1) begin
                              rem_ff     <= '0;
                              dvd_ff     <= {1'b0, ptr_ff[BYTE_W-1:0], wdata_in};
                              dvs_ff     <= eff_size_in;
                              cnt_ff     <= MOD_STEPS_TOP;
                              mod_ptr_ff <= 1'b1;
                              state_ff   <= S_DIV;
                           end else begin
                              state_ff <= S_DONE;
                           end
                        end else if ({1'b0, ptr_ff} < DEPTH_C) begin
                           idx_ff   <= ptr_ff[AW-1:0];
                           state_ff <= S_ACCESS;
                        end else begin
                           // pointer past the store: cell index is pointer mod depth
                           rem_ff     <= '0;
                           dvd_ff     <= {1'b0, ptr_ff};
                           dvs_ff     <= DEPTH_C;
                           cnt_ff     <= MOD_STEPS_TOP;
                           mod_ptr_ff <= 1'b0;
                           state_ff   <= S_DIV;
                        end
                     end
                     default: begin
                        state_ff <= S_DONE;
                     end
                  endcase
               end
            end
            S_DIV: begin
               rem_ff <= rem_in;
               dvd_ff <= {dvd_ff[SIZE_W-2:0], 1'b0};
               cnt_ff <= cnt_ff - CNT_W'(1);
               if (cnt_ff == '0) begin
                  if (mod_ptr_ff) begin
                     ptr_ff   <= rem_in[PTR_W-1:0];
                     state_ff <= S_DONE;
                  end else begin
                     idx_ff   <= rem_in[AW-1:0];
                     state_ff <= S_ACCESS;
                  end
               end
            end
            S_ACCESS: begin
               if ((func_ff == FUNC_WRITE) && wen_ff) begin
                  changed_ff <= 1'b1;
               end
               rem_ff     <= '0;
               dvd_ff     <= {1'b0, ptr_ff} + SIZE_W'(1);
               dvs_ff     <= eff_size_in;
               cnt_ff     <= MOD_STEPS_TOP;
               mod_ptr_ff <= 1'b1;
               state_ff   <= S_DIV;
            end
            S_DONE: begin
               if (!rsp_tvalid_ff || rsp_tready) begin
                  rsp_tvalid_ff <= 1'b1;
                  rsp_tdata_ff  <= {(RSP_W - PTR_W - 1 - BYTE_W)'(0), ptr_ff, flush_ff,
                                    (func_ff == FUNC_READ) ? mem_q_ff : BYTE_W'(0)};
                  state_ff      <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   `I2CE_ASSERT_NOW(a_rem_below_divisor, state_ff == S_DIV, rem_ff < dvs_ff, "remainder out of range")
   `I2CE_ASSERT_NEXT(a_hold_result, (state_ff == S_DONE) && rsp_tvalid_ff && !rsp_tready, state_ff == S_DONE, "result overwrote a stalled beat")
   `I2CE_ASSERT_NEXT(a_event_clears_mark, req_take && (func_in == FUNC_EVENT), !changed_ff, "change mark not cleared by event")

endmodule
